@@ hdl/pps_pkg.sv @@
// ----------------------------------------------------------------------------
// pps_pkg
// Shared types and constants for the preemptive priority scheduler.
// ----------------------------------------------------------------------------
package pps_pkg;

    localparam int unsigned ID_W   = 16;
    localparam int unsigned TIME_W = 32;
    localparam int unsigned BRST_W = 16;
    localparam int unsigned PRI_W  = 8;
    // id + arrival + total + start + priority
    localparam int unsigned ENTRY_W = ID_W + TIME_W + BRST_W + TIME_W + PRI_W;

    typedef enum logic {
        ACT_ARRIVE   = 1'b0,
        ACT_COMPLETE = 1'b1
    } t_action;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] arrival;
        logic [BRST_W-1:0] total;
        logic [TIME_W-1:0] start;
        logic [PRI_W-1:0]  prio;
    } t_entry;

    // Controller to datapath
    typedef struct packed {
        logic load_in;      // capture the input item
        logic run_arrival;  // start the captured arrival now
        logic push_in;      // write captured arrival at tail
        logic push_cur;     // write running task at tail
        logic set_drop;     // flag the captured arrival as dropped
        logic go_idle;      // clear running task and queue
        logic scan_rd;      // issue queue read at scan index
        logic scan_cmp;     // compare read data to best so far
        logic scan_first;   // read data is the first entry
        logic run_best;     // start the best entry now
        logic shift_rd;     // issue read at shift index + 1
        logic shift_wr;     // write read data at shift index
        logic pop;          // decrement count
        logic res_load;     // capture result
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic action;
        logic cur_valid;
        logic q_full;
        logic q_empty;
        logic preempt;
        logic scan_last;
        logic shift_last;
    } t_sts;

endpackage

@@ hdl/preemptive_priority_scheduler.sv @@
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler
// Preemptive priority scheduler with an ordered ready queue in RAM.
// ----------------------------------------------------------------------------
// One item is one scheduler event (arrival or completion) and yields one result
// item showing the running task after the event. An arrival is captured,
// decided and loaded into the result register. A completion scans the queue
// memory entry by entry, a read then a compare (registered read port), then
// compacts the entries behind the chosen one with a read and a write per
// entry, set by the single read port of the queue RAM. The result sits in an
// output register, so the next item is taken while a result still waits.
// Lower priority value is more urgent; ties go to the earlier queue entry.
// Every result reports remaining equal to total. End time wraps modulo 2^32.
module preemptive_priority_scheduler #(
    parameter int unsigned QUEUE_DEPTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic                       i_action,
    input  logic [pps_pkg::TIME_W-1:0] i_now,
    input  logic [pps_pkg::ID_W-1:0]   i_proc_id,
    input  logic [pps_pkg::TIME_W-1:0] i_proc_arrival,
    input  logic [pps_pkg::BRST_W-1:0] i_proc_burst,
    input  logic [pps_pkg::PRI_W-1:0]  i_proc_priority,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic                       o_busy_res,
    output logic [pps_pkg::ID_W-1:0]   o_run_id,
    output logic [pps_pkg::TIME_W-1:0] o_run_arrival,
    output logic [pps_pkg::BRST_W-1:0] o_run_total_burst,
    output logic [pps_pkg::TIME_W-1:0] o_run_start,
    output logic [pps_pkg::TIME_W-1:0] o_run_end,
    output logic [pps_pkg::BRST_W-1:0] o_run_remaining,
    output logic [pps_pkg::PRI_W-1:0]  o_run_priority,
    output logic                       o_dropped
);
    import pps_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // sequence each event
    pps_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // hold running task, queue and result
    pps_dp #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_action          (i_action),
        .i_now             (i_now),
        .i_proc_id         (i_proc_id),
        .i_proc_arrival    (i_proc_arrival),
        .i_proc_burst      (i_proc_burst),
        .i_proc_priority   (i_proc_priority),
        .o_busy_res        (o_busy_res),
        .o_run_id          (o_run_id),
        .o_run_arrival     (o_run_arrival),
        .o_run_total_burst (o_run_total_burst),
        .o_run_start       (o_run_start),
        .o_run_end         (o_run_end),
        .o_run_remaining   (o_run_remaining),
        .o_run_priority    (o_run_priority),
        .o_dropped         (o_dropped)
    );
endmodule

@@ hdl/pps_ram.sv @@
// ----------------------------------------------------------------------------
// pps_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module pps_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ hdl/pps_dp.sv @@
// ----------------------------------------------------------------------------
// pps_dp
// Datapath: running task, queue memory, scan and compaction, result register.
// ----------------------------------------------------------------------------
module pps_dp #(
    parameter int unsigned QUEUE_DEPTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  pps_pkg::t_cmd              i_cmd,
    output pps_pkg::t_sts              o_sts,
    input  logic                       i_action,
    input  logic [pps_pkg::TIME_W-1:0] i_now,
    input  logic [pps_pkg::ID_W-1:0]   i_proc_id,
    input  logic [pps_pkg::TIME_W-1:0] i_proc_arrival,
    input  logic [pps_pkg::BRST_W-1:0] i_proc_burst,
    input  logic [pps_pkg::PRI_W-1:0]  i_proc_priority,
    output logic                       o_busy_res,
    output logic [pps_pkg::ID_W-1:0]   o_run_id,
    output logic [pps_pkg::TIME_W-1:0] o_run_arrival,
    output logic [pps_pkg::BRST_W-1:0] o_run_total_burst,
    output logic [pps_pkg::TIME_W-1:0] o_run_start,
    output logic [pps_pkg::TIME_W-1:0] o_run_end,
    output logic [pps_pkg::BRST_W-1:0] o_run_remaining,
    output logic [pps_pkg::PRI_W-1:0]  o_run_priority,
    output logic                       o_dropped
);
    import pps_pkg::*;

    localparam int unsigned AW = $clog2(QUEUE_DEPTH);
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

    // captured item
    logic              r_action;
    logic [TIME_W-1:0] r_now;
    t_entry            r_in;

    // running task
    logic              r_cur_valid;
    t_entry            r_cur;
    logic [TIME_W-1:0] r_cur_end;

    logic [CW-1:0]     r_count;
    logic [AW-1:0]     r_idx;      // scan / shift index
    logic [AW-1:0]     r_best;
    t_entry            r_best_e;
    logic              r_drop;

    // result
    logic              r_o_busy;
    t_entry            r_o;
    logic [TIME_W-1:0] r_o_end;
    logic              r_o_drop;

    logic              we;
    logic [AW-1:0]     waddr;
    t_entry            wdata;
    logic [AW-1:0]     raddr;
    logic [ENTRY_W-1:0] rdata;
    t_entry            rd_e;
    logic [AW-1:0]     tail;

    assign rd_e = t_entry'(rdata);
    assign tail = r_count[AW-1:0];

    always_comb begin
        we    = 1'b0;
        waddr = tail;
        wdata = r_in;
        raddr = r_idx;
        if (i_cmd.push_in) begin
            we = 1'b1;
            wdata.start = '0;
        end else if (i_cmd.push_cur) begin
            we = 1'b1;
            wdata = r_cur;
        end else if (i_cmd.shift_wr) begin
            we = 1'b1;
            waddr = r_idx;
            wdata = rd_e;
        end
        if (i_cmd.shift_rd) begin
            raddr = r_idx + AW'(1);
        end
    end

    pps_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign o_sts.action     = r_action;
    assign o_sts.cur_valid  = r_cur_valid;
    assign o_sts.q_full     = (r_count >= DEPTH_C);
    assign o_sts.q_empty    = (r_count == '0);
    assign o_sts.preempt    = (r_in.prio < r_cur.prio);
    assign o_sts.scan_last  = (CW'(r_idx) + CW'(1) >= r_count);
    assign o_sts.shift_last = (CW'(r_idx) + CW'(1) >= r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_valid <= 1'b0;
            r_cur       <= '0;
            r_cur_end   <= '0;
            r_count     <= '0;
            r_idx       <= '0;
            r_drop      <= 1'b0;
        end else begin
            if (i_cmd.load_in) begin
                r_action       <= i_action;
                r_now          <= i_now;
                r_in.id        <= i_proc_id;
                r_in.arrival   <= i_proc_arrival;
                r_in.total     <= i_proc_burst;
                r_in.start     <= i_now;
                r_in.prio      <= i_proc_priority;
                r_drop         <= 1'b0;
                r_idx          <= '0;
            end
            if (i_cmd.set_drop) begin
                r_drop <= 1'b1;
            end
            if (i_cmd.push_in || i_cmd.push_cur) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.run_arrival) begin
                r_cur_valid <= 1'b1;
                r_cur       <= r_in;
                r_cur_end   <= r_now + TIME_W'(r_in.total);
            end
            if (i_cmd.go_idle) begin
                r_cur_valid <= 1'b0;
                r_cur       <= '0;
                r_cur_end   <= '0;
                r_count     <= '0;
            end
            // scan: data at r_idx is valid this cycle
            if (i_cmd.scan_cmp) begin
                if (i_cmd.scan_first || rd_e.prio < r_best_e.prio) begin
                    r_best   <= r_idx;
                    r_best_e <= rd_e;
                end
                r_idx <= r_idx + AW'(1);
            end else if (i_cmd.scan_rd) begin
                r_idx <= '0;
            end
            if (i_cmd.run_best) begin
                r_cur_valid    <= 1'b1;
                r_cur          <= '{id: r_best_e.id, arrival: r_best_e.arrival,
                                    total: r_best_e.total, start: r_now,
                                    prio: r_best_e.prio};
                r_cur_end      <= r_now + TIME_W'(r_best_e.total);
                r_idx          <= r_best;
            end
            if (i_cmd.shift_wr) begin
                r_idx <= r_idx + AW'(1);
            end
            if (i_cmd.pop) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_o_busy <= r_cur_valid;
            r_o      <= r_cur;
            r_o_end  <= r_cur_end;
            r_o_drop <= r_drop;
        end
    end

    assign o_busy_res        = r_o_busy;
    assign o_run_id          = r_o.id;
    assign o_run_arrival     = r_o.arrival;
    assign o_run_total_burst = r_o.total;
    assign o_run_start       = r_o.start;
    assign o_run_end         = r_o_end;
    assign o_run_remaining   = r_o.total;
    assign o_run_priority    = r_o.prio;
    assign o_dropped         = r_o_drop;
endmodule

@@ hdl/pps_ctrl.sv @@
// ----------------------------------------------------------------------------
// pps_ctrl
// Controller: sequences arrival handling, queue scan and compaction.
// ----------------------------------------------------------------------------
module pps_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    output logic          o_valid,
    input  logic          i_ready,
    input  pps_pkg::t_sts i_sts,
    output pps_pkg::t_cmd o_cmd
);
    import pps_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_DECIDE, S_SCAN, S_SCAN_CMP, S_SHIFT_RD, S_SHIFT_WR, S_RESULT, S_OUT
    } t_state;

    t_state r_state, n_state;
    logic   r_valid, n_valid;
    logic   r_first, n_first;

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_valid;

    always_comb begin
        n_state = r_state;
        n_valid = r_valid;
        n_first = r_first;
        o_cmd   = '0;
        if (r_valid && i_ready) begin
            n_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_sts.action == ACT_ARRIVE) begin
                    n_state = S_RESULT;
                    if (!i_sts.cur_valid) begin
                        o_cmd.run_arrival = 1'b1;
                    end else if (i_sts.q_full) begin
                        o_cmd.set_drop = 1'b1;
                    end else if (i_sts.preempt) begin
                        o_cmd.push_cur    = 1'b1;
                        o_cmd.run_arrival = 1'b1;
                    end else begin
                        o_cmd.push_in = 1'b1;
                    end
                end else if (i_sts.q_empty) begin
                    o_cmd.go_idle = 1'b1;
                    n_state = S_RESULT;
                end else begin
                    o_cmd.scan_rd = 1'b1;
                    n_first = 1'b1;
                    n_state = S_SCAN_CMP;
                end
            end
            S_SCAN: begin
                // read issued here at the incremented index
                n_state = S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                o_cmd.scan_cmp   = 1'b1;
                o_cmd.scan_first = r_first;
                n_first = 1'b0;
                if (i_sts.scan_last) begin
                    n_state = S_SHIFT_RD;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SHIFT_RD: begin
                // first cycle here: start best task, index moves to best
                if (!r_first) begin
                    o_cmd.run_best = 1'b1;
                    n_first = 1'b1;
                    n_state = S_SHIFT_RD;
                end else if (i_sts.shift_last) begin
                    o_cmd.pop = 1'b1;
                    n_state = S_RESULT;
                end else begin
                    o_cmd.shift_rd = 1'b1;
                    n_state = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR: begin
                o_cmd.shift_wr = 1'b1;
                n_state = S_SHIFT_RD;
            end
            S_RESULT: begin
                if (!r_valid || i_ready) begin
                    o_cmd.res_load = 1'b1;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_OUT: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_first <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_first <= n_first;
        end
    end
endmodule

@@ hdl/pps_checker.sv @@
// ----------------------------------------------------------------------------
// pps_checker
// Port-level checks for the preemptive priority scheduler.
// ----------------------------------------------------------------------------
module pps_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic        o_busy_res,
    input logic [15:0] o_run_id,
    input logic [15:0] o_run_total_burst,
    input logic [15:0] o_run_remaining,
    input logic [31:0] o_run_start,
    input logic [31:0] o_run_end,
    input logic        o_dropped
);
    // idle result carries zero id and end time and no drop flag
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_busy_res) |-> (o_run_id == '0 && o_run_end == '0 && !o_dropped))
        else $error("idle result not zero");

    // a dropped arrival never happens on an idle CPU
    a_drop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_dropped) |-> o_busy_res)
        else $error("drop reported while idle");

    // remaining equals total on every result
    a_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_run_remaining == o_run_total_burst))
        else $error("remaining differs from total");

    // no new item accepted the cycle after an accept
    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("back to back accept");

    // a waiting result holds its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_run_end) && $stable(o_run_start)))
        else $error("result changed while stalled");
endmodule

bind preemptive_priority_scheduler pps_checker u_pps_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_valid           (i_valid),
    .o_ready           (o_ready),
    .o_valid           (o_valid),
    .i_ready           (i_ready),
    .o_busy_res        (o_busy_res),
    .o_run_id          (o_run_id),
    .o_run_total_burst (o_run_total_burst),
    .o_run_remaining   (o_run_remaining),
    .o_run_start       (o_run_start),
    .o_run_end         (o_run_end),
    .o_dropped         (o_dropped)
);
